// ===== design/fpsc_pkg.sv =====
package fpsc_pkg;

  localparam int unsigned SampleBytesW  = 3;
  localparam int unsigned SampleFormatW = 2;
  localparam int unsigned WordW         = 32;

  localparam logic [SampleBytesW-1:0]  BytesReset = 3'd2;
  localparam logic [SampleFormatW-1:0] FmtReset   = 2'd1;

  localparam logic [SampleFormatW-1:0] FmtPcm   = 2'd1;
  localparam logic [SampleFormatW-1:0] FmtFloat = 2'd3;

  localparam logic CfgIdxBytes  = 1'b0;
  localparam logic CfgIdxFormat = 1'b1;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             clipped;
    logic             unsupported;
    logic             last;
  } result_t;

endpackage

// ===== design/fpsc_core.sv =====
module fpsc_core (
  input  logic                               req_type_i,
  input  logic [fpsc_pkg::WordW-1:0]         word_i,
  input  logic                               last_i,
  input  logic [fpsc_pkg::SampleBytesW-1:0]  bytes_i,
  input  logic [fpsc_pkg::SampleFormatW-1:0] format_i,
  output fpsc_pkg::result_t                  res_o
);
  import fpsc_pkg::*;

  logic        unsup, pass;
  logic [5:0]  k;
  logic [32:0] lim;
  logic [31:0] mask;
  logic [31:0] pcm_res;
  logic        pcm_clip;
  logic [31:0] flt_res;

  // Float to PCM.
  logic        neg, sat, ge, gt, nan;
  logic [7:0]  e;
  logic [23:0] m;
  logic signed [10:0] s;
  logic [32:0] ip, frac_mask, frac, halfv, pm, qm, v, ipg;
  logic [5:0]  sh;

  // PCM to float.
  logic [31:0] raw, mag;
  logic        pneg;
  logic [5:0]  p;
  logic [31:0] norm;
  logic [24:0] keep;
  logic        rbit, sticky;
  logic [7:0]  expf;

  always_comb begin
    unsup = (bytes_i < 3'd1) || (bytes_i > 3'd4) ||
            (bytes_i == 3'd4 && format_i != FmtPcm && format_i != FmtFloat);
    pass  = (bytes_i == 3'd4) && (format_i == FmtFloat);
    k     = 6'({bytes_i, 3'b000}) - 6'd1;
    lim   = 33'd1 << k;
    mask  = 32'((34'd1 << {bytes_i, 3'b000}) - 34'd1);

    neg = word_i[31];
    e   = word_i[30:23];
    nan = (e == 8'hFF) && (word_i[22:0] != 23'd0);
    m   = (e != 8'd0) ? {1'b1, word_i[22:0]} : {1'b0, word_i[22:0]};
    s   = 11'sd0 + ((e != 8'd0) ? $signed({3'b000, e}) : 11'sd1) - 11'sd150
          + $signed({5'd0, k});
    sat = (e == 8'hFF) || (s >= 11'sd9);
    ip = '0; ge = 1'b0; gt = 1'b0; sh = '0;
    frac_mask = '0; frac = '0; halfv = '0;
    if (!sat) begin
      if (s >= 11'sd0) begin
        ip = {9'd0, m} << s[3:0];
      end else if (s > -11'sd33) begin
        sh        = 6'(-s);
        frac_mask = (33'd1 << sh) - 33'd1;
        frac      = {9'd0, m} & frac_mask;
        halfv     = 33'd1 << (sh - 6'd1);
        ip        = {9'd0, m} >> sh;
        ge        = frac >= halfv;
        gt        = frac > halfv;
      end
    end
    pcm_clip = nan;
    ipg = ip + {32'd0, ge};
    pm = '0; qm = '0; v = '0;
    if (!neg) begin
      pm = sat ? lim : ipg;
      if (pm > lim - 33'd1) begin
        pm = lim - 33'd1;
        pcm_clip = 1'b1;
      end
      v = pm;
    end else begin
      if (sat) qm = lim + 33'd1;
      else if (bytes_i == 3'd1) qm = ip + {32'd0, gt};
      else qm = (ipg != 33'd0) ? ipg - 33'd1 : 33'd0;
      if (qm > lim) begin
        qm = lim;
        pcm_clip = 1'b1;
      end
      v = 33'd0 - qm;
    end
    if (bytes_i == 3'd1) v = v + 33'd128;
    pcm_res = nan ? 32'd0 : (v[31:0] & mask);

    raw = word_i & mask;
    if (bytes_i == 3'd1) begin
      pneg = raw < 32'd128;
      mag  = pneg ? 32'd128 - raw : raw - 32'd128;
    end else begin
      pneg = raw[k[4:0]];
      mag  = pneg ? 32'(({1'b0, mask} + 33'd1) - {1'b0, raw}) : raw;
    end
    p = '0;
    for (int i = 0; i < 32; i++) if (mag[i]) p = 6'(i);
    norm   = mag << (6'd31 - p);
    keep   = {1'b0, norm[31:8]};
    rbit   = norm[7];
    sticky = norm[6:0] != 7'd0;
    if (rbit && (sticky || keep[0])) keep = keep + 25'd1;
    expf = 8'({2'b00, p} + 8'd127 - {2'b00, k});
    if (keep[24]) expf = expf + 8'd1;
    flt_res = (mag == 32'd0) ? 32'd0 : {pneg, expf, keep[22:0]};

    res_o.last        = last_i;
    res_o.unsupported = unsup;
    res_o.clipped     = 1'b0;
    if (unsup) res_o.word = '0;
    else if (pass) res_o.word = word_i;
    else if (req_type_i) res_o.word = flt_res;
    else begin
      res_o.word    = pcm_res;
      res_o.clipped = pcm_clip;
    end
  end

endmodule

// ===== design/float_pcm_sample_converter_unit.sv =====
// Float32 / PCM audio sample converter.
// Slave stream s_axis_*: tdata[31:0] is the sample word, tuser[0] the request
// type (0 float to PCM, 1 PCM to float), tlast marks the final sample.
// Master stream m_axis_*: tdata[31:0] is the result word, tuser[0] clipped,
// tuser[1] unsupported, tlast copies the input marker.
// Configuration channel cfg_*: index 0 sample_bytes, index 1 sample_format.
// Write it only while no transaction is in flight.
// Each sample is registered at the input, converted by one combinational
// pass, and registered at the output. One sample is taken every cycle while
// the output is not stalled. The input stage can still take a sample while
// a finished result waits, because each stage advances whenever the one
// after it is empty or being emptied. A stalled receiver therefore backs up
// at most two samples before s_axis_tready falls.
// Reset empties both stages and loads sample_bytes 2 and sample_format 1.
module float_pcm_sample_converter_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [31:0]                        s_axis_tdata, // sample_word
  input  logic                               s_axis_tuser, // req_type
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [31:0]                        m_axis_tdata, // result_word
  output logic [1:0]                         m_axis_tuser, // clipped, unsupported
  output logic                               m_axis_tlast,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic                               cfg_index_i,
  input  logic [fpsc_pkg::SampleBytesW-1:0]  cfg_data_i
);
  import fpsc_pkg::*;

  logic [SampleBytesW-1:0]  bytes_q;
  logic [SampleFormatW-1:0] fmt_q;
  logic                     in_vld_q, out_vld_q;
  logic [WordW-1:0]         in_word_q;
  logic                     in_type_q, in_last_q;
  result_t                  res_d, res_q;
  logic                     out_adv, in_adv;

  assign cfg_ready_o   = 1'b1;
  assign out_adv       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || out_adv;
  assign in_adv        = s_axis_tvalid && s_axis_tready;

  fpsc_core u_core (
    .req_type_i (in_type_q),
    .word_i     (in_word_q),
    .last_i     (in_last_q),
    .bytes_i    (bytes_q),
    .format_i   (fmt_q),
    .res_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_q   <= BytesReset;
      fmt_q     <= FmtReset;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CfgIdxBytes) bytes_q <= cfg_data_i;
        else fmt_q <= cfg_data_i[SampleFormatW-1:0];
      end
      if (s_axis_tready) in_vld_q <= s_axis_tvalid;
      if (out_adv) out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv) begin
      in_word_q <= s_axis_tdata;
      in_type_q <= s_axis_tuser;
      in_last_q <= s_axis_tlast;
    end
    if (out_adv) res_q <= res_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = res_q.word;
  assign m_axis_tuser  = {res_q.unsupported, res_q.clipped};
  assign m_axis_tlast  = res_q.last;

  a_unsup_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == 32'd0 && !m_axis_tuser[0])
    else $error("unsupported result not zero");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_adv |=> in_vld_q)
    else $error("accepted sample lost");

endmodule
